// ----- rtl/core/fcc_pkg.sv -----
`default_nettype none

package fcc_pkg;

    localparam int unsigned PAGE_WORDS         = 32;
    localparam int unsigned MAX_TRANSFER_BYTES = 65536;
    localparam int unsigned XFER_WORDS         = MAX_TRANSFER_BYTES / 4;

    typedef enum logic [1:0] {
        OP_COMMAND    = 2'd0,
        OP_WRITE_DMA  = 2'd1,
        OP_READ_DMA   = 2'd2,
        OP_STATUS_REG = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_ERASE  = 3'd1,
        MODE_WRITE  = 3'd2,
        MODE_READ   = 3'd3,
        MODE_STATUS = 3'd4
    } t_mode;

    // command codes in the top byte of the command word
    localparam logic [7:0] CMD_EXECUTE      = 8'hD2;
    localparam logic [7:0] CMD_STATUS_MODE  = 8'hE1;
    localparam logic [7:0] CMD_READ_MODE    = 8'hF0;
    localparam logic [7:0] CMD_SET_PAGE     = 8'h4B;
    localparam logic [7:0] CMD_ERASE_MODE   = 8'h78;
    localparam logic [7:0] CMD_WRITE_MODE   = 8'hB4;
    localparam logic [7:0] CMD_SET_PAGE_WR  = 8'hA5;

    localparam logic [63:0] STATUS_STATUS_MODE = 64'h1111800100C20000;
    localparam logic [63:0] STATUS_READ_MODE   = 64'h11118004F0000000;
    localparam logic [63:0] STATUS_ERASE_MODE  = 64'h1111800800C20000;
    localparam logic [63:0] STATUS_SET_PAGE_WR = 64'h1111800400C20000;

    localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// ----- rtl/core/fcc_cmd_if.sv -----
`default_nettype none

interface fcc_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] command_word;
    logic [15:0] start_offset;
    logic [13:0] word_index;
    logic [31:0] write_data;

    modport source (
        output valid, opcode, command_word, start_offset, word_index, write_data,
        input  ready
    );
    modport sink (
        input  valid, opcode, command_word, start_offset, word_index, write_data,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/fcc_rsp_if.sv -----
`default_nettype none

interface fcc_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        data_valid;
    logic [2:0]  mode;

    modport source (
        output valid, read_data, data_valid, mode,
        input  ready
    );
    modport sink (
        input  valid, read_data, data_valid, mode,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/flash_command_controller.sv -----
`default_nettype none

// Page flash command controller. One command beat in gives one response beat out.
// The flash contents sit in a single-port-write, dual-read synchronous RAM of
// PAGES*32 words. After reset the block sweeps that RAM to all-ones, one word a
// cycle, so i_cmd.ready stays low until the whole RAM is cleared.
// Command writes, write-DMA beats, status register reads and status or refused
// read-DMA beats are answered straight from the idle state; a read-DMA beat in read
// mode first passes through a wait state, as the store RAM read is registered and
// both neighboring words of an unaligned fetch are read together. An execute command
// that erases or programs a page in range answers at once, then holds off the next
// beat while it walks the page, one store word a cycle (the page buffer RAM read
// sits in the cycle before the store write). A new beat is taken while the previous
// response is being taken in the same cycle.
module flash_command_controller #(
    parameter int unsigned PAGES = 1024
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fcc_cmd_if.sink    i_cmd,
    fcc_rsp_if.source  o_rsp
);

    localparam int unsigned STORE_WORDS = PAGES * fcc_pkg::PAGE_WORDS;
    localparam int unsigned SW          = $clog2(STORE_WORDS);
    localparam int unsigned IDX_W       = ((SW > 16) ? SW : 16) + 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RDWAIT,
        S_EXEC
    } t_state;

    t_state          r_state;
    fcc_pkg::t_mode  r_mode;
    logic [15:0]     r_page;
    logic [63:0]     r_status;
    logic [SW-1:0]   r_clr;
    logic [5:0]      r_cnt;
    logic [4:0]      r_widx;
    logic            r_wpend;
    logic            r_prog;
    logic            r_in0;
    logic            r_in1;
    logic            r_half;

    logic            r_out_valid;
    logic [31:0]     r_read_data;
    logic            r_data_valid;
    logic [2:0]      r_mode_out;

    logic [31:0]     store_mem [STORE_WORDS];
    logic [31:0]     pbuf_mem  [fcc_pkg::PAGE_WORDS];
    logic [31:0]     r_rd0;
    logic [31:0]     r_rd1;
    logic [31:0]     r_pb_rd;

    logic            accept;
    logic [7:0]      cmd_code;
    logic [17:0]     byte_addr;
    logic [15:0]     wa0;
    logic [15:0]     wa1;
    logic [IDX_W-1:0] wa0_x;
    logic [IDX_W-1:0] wa1_x;
    logic            in_xfer;
    logic            page_ok;
    logic [20:0]     exec_idx;

    logic            st_we;
    logic [SW-1:0]   st_waddr;
    logic [31:0]     st_wdata;
    logic            pb_we;

    logic [31:0]     w0;
    logic [31:0]     w1;
    logic [31:0]     n_fetch;

    assign i_cmd.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign cmd_code    = i_cmd.command_word[31:24];

    // byte address 2*offset + 4*index, bit 0 is always clear
    assign byte_addr = {1'b0, i_cmd.start_offset, 1'b0} + {2'b00, i_cmd.word_index, 2'b00};
    assign wa0       = byte_addr[17:2];
    assign wa1       = wa0 + 16'd1;
    assign wa0_x     = IDX_W'(wa0);
    assign wa1_x     = IDX_W'(wa1);
    assign in_xfer   = {1'b0, i_cmd.word_index} < 15'(fcc_pkg::XFER_WORDS);
    assign page_ok   = {1'b0, r_page} < 17'(PAGES);
    assign exec_idx  = {r_page, r_widx};

    assign pb_we = accept && (i_cmd.opcode == fcc_pkg::OP_WRITE_DMA)
                   && (r_mode == fcc_pkg::MODE_WRITE)
                   && (i_cmd.word_index < 14'(fcc_pkg::PAGE_WORDS));

    always_comb begin
        st_we    = 1'b0;
        st_waddr = r_clr;
        st_wdata = fcc_pkg::ERASED_WORD;
        if (r_state == S_CLEAR) begin
            st_we = 1'b1;
        end else if (r_wpend) begin
            st_we    = 1'b1;
            st_waddr = exec_idx[SW-1:0];
            st_wdata = r_prog ? r_pb_rd : fcc_pkg::ERASED_WORD;
        end
    end

    // words beyond the store read as erased
    assign w0      = r_in0 ? r_rd0 : fcc_pkg::ERASED_WORD;
    assign w1      = r_in1 ? r_rd1 : fcc_pkg::ERASED_WORD;
    assign n_fetch = r_half ? {w1[15:0], w0[31:16]} : w0;

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            store_mem[st_waddr] <= st_wdata;
        end
        r_rd0 <= store_mem[wa0_x[SW-1:0]];
        r_rd1 <= store_mem[wa1_x[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (pb_we) begin
            pbuf_mem[i_cmd.word_index[4:0]] <= i_cmd.write_data;
        end
        r_pb_rd <= pbuf_mem[r_cnt[4:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_mode      <= fcc_pkg::MODE_IDLE;
            r_page      <= '0;
            r_status    <= '0;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            r_wpend <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + SW'(1);
                    if (r_clr == SW'(STORE_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_out_valid  <= 1'b1;
                        r_read_data  <= '0;
                        r_data_valid <= 1'b0;
                        r_mode_out   <= r_mode;
                        unique case (fcc_pkg::t_opcode'(i_cmd.opcode))
                            fcc_pkg::OP_COMMAND: begin
                                unique case (cmd_code)
                                    fcc_pkg::CMD_EXECUTE: begin
                                        r_mode     <= fcc_pkg::MODE_IDLE;
                                        r_mode_out <= fcc_pkg::MODE_IDLE;
                                        r_prog     <= (r_mode == fcc_pkg::MODE_WRITE);
                                        r_cnt      <= '0;
                                        if (page_ok && (r_mode == fcc_pkg::MODE_ERASE
                                                || r_mode == fcc_pkg::MODE_WRITE)) begin
                                            r_state <= S_EXEC;
                                        end
                                    end
                                    fcc_pkg::CMD_STATUS_MODE: begin
                                        r_mode     <= fcc_pkg::MODE_STATUS;
                                        r_mode_out <= fcc_pkg::MODE_STATUS;
                                        r_status   <= fcc_pkg::STATUS_STATUS_MODE;
                                    end
                                    fcc_pkg::CMD_READ_MODE: begin
                                        r_mode     <= fcc_pkg::MODE_READ;
                                        r_mode_out <= fcc_pkg::MODE_READ;
                                        r_status   <= fcc_pkg::STATUS_READ_MODE;
                                    end
                                    fcc_pkg::CMD_SET_PAGE: begin
                                        r_page <= i_cmd.command_word[15:0];
                                    end
                                    fcc_pkg::CMD_ERASE_MODE: begin
                                        r_mode     <= fcc_pkg::MODE_ERASE;
                                        r_mode_out <= fcc_pkg::MODE_ERASE;
                                        r_status   <= fcc_pkg::STATUS_ERASE_MODE;
                                    end
                                    fcc_pkg::CMD_WRITE_MODE: begin
                                        r_mode     <= fcc_pkg::MODE_WRITE;
                                        r_mode_out <= fcc_pkg::MODE_WRITE;
                                    end
                                    fcc_pkg::CMD_SET_PAGE_WR: begin
                                        r_page   <= i_cmd.command_word[15:0];
                                        r_status <= fcc_pkg::STATUS_SET_PAGE_WR;
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                            fcc_pkg::OP_WRITE_DMA: begin
                            end
                            fcc_pkg::OP_READ_DMA: begin
                                if (r_mode == fcc_pkg::MODE_READ && in_xfer) begin
                                    // response waits in S_RDWAIT for the registered store read
                                    r_out_valid <= 1'b0;
                                    r_in0       <= wa0_x < IDX_W'(STORE_WORDS);
                                    r_in1       <= wa1_x < IDX_W'(STORE_WORDS);
                                    r_half      <= byte_addr[1];
                                    r_state     <= S_RDWAIT;
                                end else if (r_mode == fcc_pkg::MODE_STATUS) begin
                                    if (i_cmd.word_index == 14'd0) begin
                                        r_read_data  <= r_status[63:32];
                                        r_data_valid <= 1'b1;
                                    end else if (i_cmd.word_index == 14'd1) begin
                                        r_read_data  <= r_status[31:0];
                                        r_data_valid <= 1'b1;
                                    end
                                end
                            end
                            fcc_pkg::OP_STATUS_REG: begin
                                r_read_data  <= r_status[63:32];
                                r_data_valid <= 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RDWAIT: begin
                    r_out_valid  <= 1'b1;
                    r_read_data  <= n_fetch;
                    r_data_valid <= 1'b1;
                    r_state      <= S_IDLE;
                end
                S_EXEC: begin
                    // page buffer read at r_cnt, store write in the cycle after
                    r_cnt   <= r_cnt + 6'd1;
                    r_widx  <= r_cnt[4:0];
                    r_wpend <= (r_cnt < 6'(fcc_pkg::PAGE_WORDS));
                    if (r_cnt == 6'(fcc_pkg::PAGE_WORDS)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_data  = r_read_data;
    assign o_rsp.data_valid = r_data_valid;
    assign o_rsp.mode       = r_mode_out;

endmodule

`default_nettype wire

// ----- rtl/core/fcc_checker.sv -----
`default_nettype none

module fcc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_read_data,
    input wire logic        i_data_valid,
    input wire logic [2:0]  i_mode
);

    // a stalled response beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_read_data) && $stable(i_data_valid) && $stable(i_mode))
        else $error("response beat dropped or changed while stalled");

    // a new command beat is only taken when the response slot frees up
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !(i_out_valid && !i_out_ready))
        else $error("command taken while response slot is full");

    // responses without a word carry zero data
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_data_valid |-> i_read_data == 32'd0)
        else $error("response without a word carries data");

    // store sweep holds off commands right after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_in_ready && !i_out_valid)
        else $error("block ready before the store sweep");

endmodule

bind flash_command_controller fcc_checker u_fcc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_read_data  (o_rsp.read_data),
    .i_data_valid (o_rsp.data_valid),
    .i_mode       (o_rsp.mode)
);

`default_nettype wire

// ----- tb/tb_flash_command_controller.sv -----
`timescale 1ns / 100ps

module tb_flash_command_controller;

    localparam int unsigned NUM_PAGES     = 1024;
    localparam int unsigned STORE_WORDS   = NUM_PAGES * fcc_pkg::PAGE_WORDS;
    localparam int unsigned STORE_BYTES   = STORE_WORDS * 4;
    localparam int unsigned RANDOM_BEATS  = 350;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned DRAIN_LIMIT   = 50000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned LONG_HOLD     = 300;
    localparam real         CLK_PERIOD    = 8.0;

    // top byte that no command decodes
    localparam logic [7:0] CMD_UNKNOWN = 8'hFF;
    localparam logic [7:0] KNOWN_CMDS [7] = '{
        fcc_pkg::CMD_EXECUTE, fcc_pkg::CMD_STATUS_MODE, fcc_pkg::CMD_READ_MODE,
        fcc_pkg::CMD_SET_PAGE, fcc_pkg::CMD_ERASE_MODE, fcc_pkg::CMD_WRITE_MODE,
        fcc_pkg::CMD_SET_PAGE_WR
    };

    typedef struct packed {
        logic [31:0] data;
        logic        dvalid;
        logic [2:0]  mode;
    } t_flash_answer;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    fcc_cmd_if cmd_if ();
    fcc_rsp_if rsp_if ();

    flash_command_controller #(
        .PAGES (NUM_PAGES)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // device image kept alongside the block
    fcc_pkg::t_mode flash_mode;
    logic [15:0]    flash_page;
    logic [63:0]    flash_status;
    logic [31:0]    flash_buffer [fcc_pkg::PAGE_WORDS];
    logic [31:0]    flash_image  [STORE_WORDS];

    t_flash_answer pending_answers [$];

    int unsigned fail_count  = 0;
    int unsigned beats_sent  = 0;
    int unsigned burst_left  = 0;
    bit          steady_send = 1'b0;
    int unsigned hold_left   = 0;

    initial begin
        flash_mode   = fcc_pkg::MODE_IDLE;
        flash_page   = '0;
        flash_status = '0;
        foreach (flash_image[i]) flash_image[i] = fcc_pkg::ERASED_WORD;
    end

    function automatic t_flash_answer predict_answer(fcc_pkg::t_opcode op, logic [31:0] cmd,
                                                     logic [15:0] soff, logic [13:0] widx,
                                                     logic [31:0] wdata);
        t_flash_answer ans;
        int unsigned   base;
        int unsigned   addr;
        int unsigned   baddr;
        logic [7:0]    byte_val;
        ans = '0;
        case (op)
            fcc_pkg::OP_COMMAND: begin
                case (cmd[31:24])
                    fcc_pkg::CMD_EXECUTE: begin
                        if (flash_page < NUM_PAGES) begin
                            base = int'(flash_page) * fcc_pkg::PAGE_WORDS;
                            for (int i = 0; i < fcc_pkg::PAGE_WORDS; i++) begin
                                if (flash_mode == fcc_pkg::MODE_ERASE) begin
                                    flash_image[base + i] = fcc_pkg::ERASED_WORD;
                                end else if (flash_mode == fcc_pkg::MODE_WRITE) begin
                                    flash_image[base + i] = flash_buffer[i];
                                end
                            end
                        end
                        flash_mode = fcc_pkg::MODE_IDLE;
                    end
                    fcc_pkg::CMD_STATUS_MODE: begin
                        flash_mode   = fcc_pkg::MODE_STATUS;
                        flash_status = fcc_pkg::STATUS_STATUS_MODE;
                    end
                    fcc_pkg::CMD_READ_MODE: begin
                        flash_mode   = fcc_pkg::MODE_READ;
                        flash_status = fcc_pkg::STATUS_READ_MODE;
                    end
                    fcc_pkg::CMD_SET_PAGE: flash_page = cmd[15:0];
                    fcc_pkg::CMD_ERASE_MODE: begin
                        flash_mode   = fcc_pkg::MODE_ERASE;
                        flash_status = fcc_pkg::STATUS_ERASE_MODE;
                    end
                    fcc_pkg::CMD_WRITE_MODE: flash_mode = fcc_pkg::MODE_WRITE;
                    fcc_pkg::CMD_SET_PAGE_WR: begin
                        flash_page   = cmd[15:0];
                        flash_status = fcc_pkg::STATUS_SET_PAGE_WR;
                    end
                    default: ;
                endcase
            end
            fcc_pkg::OP_WRITE_DMA: begin
                if (flash_mode == fcc_pkg::MODE_WRITE && widx < fcc_pkg::PAGE_WORDS) begin
                    flash_buffer[widx] = wdata;
                end
            end
            fcc_pkg::OP_READ_DMA: begin
                if (flash_mode == fcc_pkg::MODE_READ) begin
                    if (int'(widx) * 4 + 4 <= fcc_pkg::MAX_TRANSFER_BYTES) begin
                        addr = 2 * int'(soff) + 4 * int'(widx);
                        // bytes past the end of the store read as erased
                        for (int b = 0; b < 4; b++) begin
                            baddr = addr + b;
                            if (baddr >= STORE_BYTES) begin
                                byte_val = 8'hFF;
                            end else begin
                                byte_val = 8'(flash_image[baddr >> 2] >> (8 * (baddr % 4)));
                            end
                            ans.data[8 * b +: 8] = byte_val;
                        end
                        ans.dvalid = 1'b1;
                    end
                end else if (flash_mode == fcc_pkg::MODE_STATUS && widx < 2) begin
                    ans.data   = (widx == 0) ? flash_status[63:32] : flash_status[31:0];
                    ans.dvalid = 1'b1;
                end
            end
            default: begin
                ans.data   = flash_status[63:32];
                ans.dvalid = 1'b1;
            end
        endcase
        ans.mode = flash_mode;
        return ans;
    endfunction

    always @(posedge clk) begin : beat_monitor
        t_flash_answer want;
        if (rst_n) begin
            if (cmd_if.valid && cmd_if.ready) begin
                pending_answers.push_back(predict_answer(fcc_pkg::t_opcode'(cmd_if.opcode),
                    cmd_if.command_word, cmd_if.start_offset, cmd_if.word_index,
                    cmd_if.write_data));
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_answers.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected response beat: %h %b %0d",
                                 $realtime, rsp_if.read_data, rsp_if.data_valid, rsp_if.mode);
                    end
                end else begin
                    want = pending_answers.pop_front();
                    if (rsp_if.read_data !== want.data || rsp_if.data_valid !== want.dvalid ||
                        rsp_if.mode !== want.mode) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch: expected %h %b %0d, got %h %b %0d",
                                     $realtime, want.data, want.dvalid, want.mode,
                                     rsp_if.read_data, rsp_if.data_valid, rsp_if.mode);
                        end
                    end
                end
            end
        end
    end

    // response side: long hold when asked, otherwise a stall pattern that changes now and then
    always @(negedge clk) begin : response_sink
        logic [15:0] ready_pattern;
        int unsigned pattern_age;
        int unsigned pattern_pos;
        if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
        end else begin
            if (pattern_age == 0) begin
                pattern_age = $urandom_range(32, 128);
                case ($urandom_range(0, 3))
                    0:       ready_pattern = '1;
                    1:       ready_pattern = 16'($urandom);
                    2:       ready_pattern = 16'($urandom | $urandom);
                    default: ready_pattern = 16'($urandom & $urandom) | 16'h0101;
                endcase
            end
            pattern_age--;
            rsp_if.ready <= ready_pattern[pattern_pos % 16];
            pattern_pos++;
        end
    end

    task automatic send_beat(fcc_pkg::t_opcode op, logic [31:0] cmd, logic [15:0] soff,
                             logic [13:0] widx, logic [31:0] wdata);
        int unsigned gap;
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (steady_send || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                cmd_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        cmd_if.valid        <= 1'b1;
        cmd_if.opcode       <= op;
        cmd_if.command_word <= cmd;
        cmd_if.start_offset <= soff;
        cmd_if.word_index   <= widx;
        cmd_if.write_data   <= wdata;
        do @(posedge clk); while (!cmd_if.ready);
        beats_sent++;
    endtask

    task automatic send_command(logic [7:0] code, logic [15:0] page);
        send_beat(fcc_pkg::OP_COMMAND, {code, 8'($urandom), page}, 16'($urandom),
                  14'($urandom), $urandom);
    endtask

    task automatic send_write_word(logic [13:0] widx, logic [31:0] wdata);
        send_beat(fcc_pkg::OP_WRITE_DMA, $urandom, 16'($urandom), widx, wdata);
    endtask

    task automatic send_read_word(logic [15:0] soff, logic [13:0] widx);
        send_beat(fcc_pkg::OP_READ_DMA, $urandom, soff, widx, $urandom);
    endtask

    task automatic send_status_read();
        send_beat(fcc_pkg::OP_STATUS_REG, $urandom, 16'($urandom), 14'($urandom), $urandom);
    endtask

    // mostly a few low and high pages so that reads hit programmed data
    function automatic logic [15:0] pick_page();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, 7));
            6, 7:             return 16'($urandom_range(NUM_PAGES - 8, NUM_PAGES - 1));
            8:                return 16'($urandom_range(0, NUM_PAGES - 1));
            default:          return 16'($urandom);
        endcase
    endfunction

    task automatic select_page(logic [15:0] page);
        send_command($urandom_range(0, 1) ? fcc_pkg::CMD_SET_PAGE : fcc_pkg::CMD_SET_PAGE_WR,
                     page);
    endtask

    task automatic program_page(logic [15:0] page, int unsigned words, bit execute);
        int unsigned rot;
        rot = $urandom_range(0, fcc_pkg::PAGE_WORDS - 1);
        select_page(page);
        send_command(fcc_pkg::CMD_WRITE_MODE, 16'($urandom));
        for (int i = 0; i < words; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                send_write_word(14'($urandom_range(fcc_pkg::PAGE_WORDS, 16383)), $urandom);
            end
            send_write_word(14'((i + rot) % fcc_pkg::PAGE_WORDS), $urandom);
        end
        if (execute) send_command(fcc_pkg::CMD_EXECUTE, 16'($urandom));
    endtask

    task automatic erase_page(logic [15:0] page);
        select_page(page);
        send_command(fcc_pkg::CMD_ERASE_MODE, 16'($urandom));
        send_command(fcc_pkg::CMD_EXECUTE, 16'($urandom));
    endtask

    task automatic read_burst(logic [15:0] page, int unsigned count);
        logic [15:0] soff;
        int unsigned first;
        soff  = 16'(int'(page) * 64 + $urandom_range(0, 63));
        first = $urandom_range(0, 4);
        send_command(fcc_pkg::CMD_READ_MODE, 16'($urandom));
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_read_word(16'($urandom), 14'($urandom));
            end else begin
                send_read_word(soff, 14'(first + i));
            end
        end
    endtask

    task automatic test_status_and_idle();
        send_status_read();
        send_read_word(16'h0000, 14'h0000);
        send_write_word(14'h0000, 32'h1234_5678);
        send_command(CMD_UNKNOWN, 16'hFFFF);
        send_beat(fcc_pkg::OP_COMMAND, 32'h0000_0000, 16'h0000, 14'h0000, 32'h0000_0000);
        send_command(fcc_pkg::CMD_STATUS_MODE, 16'h0000);
        send_read_word(16'hFFFF, 14'd0);
        send_read_word(16'h0000, 14'd1);
        send_read_word(16'h0000, 14'd2);
        send_read_word(16'h0000, 14'h3FFF);
        send_status_read();
        send_command(fcc_pkg::CMD_READ_MODE, 16'h0000);
        send_status_read();
        send_command(fcc_pkg::CMD_EXECUTE, 16'h0000);
    endtask

    // runs before anything executes in write mode, so the whole page buffer is written
    task automatic test_program_and_read();
        program_page(16'd0, fcc_pkg::PAGE_WORDS, 1'b0);
        send_write_word(14'd0, 32'h0000_0000);
        send_write_word(14'd31, 32'hFFFF_FFFF);
        send_write_word(14'h3FFF, $urandom);
        send_command(fcc_pkg::CMD_EXECUTE, 16'h0000);
        send_command(fcc_pkg::CMD_READ_MODE, 16'h0000);
        send_read_word(16'd0, 14'd0);
        send_read_word(16'd1, 14'd0);
        send_read_word(16'd0, 14'd31);
        send_read_word(16'hFFFF, 14'd0);
        send_read_word(16'hFFFF, 14'h3FFF);
    endtask

    task automatic test_erase_and_dropped_pages();
        program_page(16'(NUM_PAGES - 1), fcc_pkg::PAGE_WORDS, 1'b1);
        erase_page(16'd0);
        erase_page(16'hFFFF);
        program_page(16'(NUM_PAGES), 4, 1'b1);
        send_command(fcc_pkg::CMD_EXECUTE, 16'h0000);
        send_command(fcc_pkg::CMD_READ_MODE, 16'h0000);
        send_read_word(16'd0, 14'd0);
        send_read_word(16'((NUM_PAGES - 1) * 64), 14'd5);
        send_read_word(16'hFFFE, 14'd0);
    endtask

    task automatic test_random_traffic();
        int unsigned target;
        logic [31:0] cmd;
        target = beats_sent + RANDOM_BEATS;
        while (beats_sent < target) begin
            case ($urandom_range(0, 99)) inside
                [0:24]:  program_page(pick_page(), $urandom_range(1, fcc_pkg::PAGE_WORDS),
                                      $urandom_range(0, 9) != 0);
                [25:39]: erase_page(pick_page());
                [40:69]: read_burst(pick_page(), $urandom_range(1, 12));
                [70:79]: begin
                    send_command(fcc_pkg::CMD_STATUS_MODE, 16'($urandom));
                    repeat ($urandom_range(1, 3)) send_read_word(16'($urandom),
                                                                 14'($urandom_range(0, 3)));
                    send_status_read();
                end
                default: begin
                    cmd = $urandom;
                    if ($urandom_range(0, 1)) cmd[31:24] = KNOWN_CMDS[$urandom_range(0, 6)];
                    send_beat(fcc_pkg::t_opcode'($urandom_range(0, 3)), cmd, 16'($urandom),
                              14'($urandom), $urandom);
                end
            endcase
        end
    endtask

    // the sink holds off for a long stretch while beats keep coming
    task automatic test_backpressure();
        send_command(fcc_pkg::CMD_READ_MODE, 16'h0000);
        steady_send = 1'b1;
        hold_left   = LONG_HOLD;
        for (int i = 0; i < 40; i++) begin
            if (i % 4 == 3) begin
                send_status_read();
            end else begin
                send_read_word(16'(int'(pick_page()) * 64), 14'($urandom_range(0, 31)));
            end
        end
        steady_send = 1'b0;
    endtask

    initial begin : regression
        int unsigned waited;
        cmd_if.valid        = 1'b0;
        cmd_if.opcode       = fcc_pkg::OP_COMMAND;
        cmd_if.command_word = '0;
        cmd_if.start_offset = '0;
        cmd_if.word_index   = '0;
        cmd_if.write_data   = '0;
        rsp_if.ready        = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_status_and_idle();
        test_program_and_read();
        test_erase_and_dropped_pages();
        test_random_traffic();
        test_backpressure();

        @(negedge clk);
        cmd_if.valid <= 1'b0;
        waited = 0;
        while (pending_answers.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_answers.size() != 0) begin
            fail_count++;
            $display("%0d response beats never arrived", pending_answers.size());
        end
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/fcc_pkg.sv
rtl/core/fcc_cmd_if.sv
rtl/core/fcc_rsp_if.sv
rtl/core/flash_command_controller.sv
rtl/core/fcc_checker.sv
tb/tb_flash_command_controller.sv
